### src/tfn_pkg.sv
// Package for the triangle flat normal pipeline: widths, payload types, helpers.
`timescale 1ns / 1ps
package tfn_pkg;

  localparam int POS_W      = 24;
  localparam int NORM_W     = 16;
  localparam int CROSS_BITS = 24;
  localparam int RSQ_SHIFT  = 54;

  localparam int EDGE_W  = POS_W + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = PROD_W;
  localparam int TOP_W   = $clog2(MAG_W + 1);
  localparam int SQ_W    = 2 * CROSS_BITS;
  localparam int LEN_W   = SQ_W + 2;
  localparam int R_W     = 32;
  localparam int PR_W    = R_W + LEN_W;
  localparam int CAND_W  = LEN_W + 2 * (R_W - 1) + 2;
  localparam int MUL_W   = CROSS_BITS + R_W;
  localparam int RND_K   = RSQ_SHIFT - (NORM_W - 1);
  localparam int LATENCY = 9 + R_W;

  localparam logic signed [NORM_W-1:0] NORM_MAX = {1'b0, {(NORM_W-1){1'b1}}};

  typedef struct packed {
    logic signed [POS_W-1:0] ax;
    logic signed [POS_W-1:0] ay;
    logic signed [POS_W-1:0] az;
    logic signed [POS_W-1:0] bx;
    logic signed [POS_W-1:0] by;
    logic signed [POS_W-1:0] bz;
    logic signed [POS_W-1:0] cx;
    logic signed [POS_W-1:0] cy;
    logic signed [POS_W-1:0] cz;
  } tfn_in_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nz;
    logic                     degenerate;
  } tfn_out_t;

  typedef struct packed {
    logic [2:0][CROSS_BITS-1:0] sc;
    logic [2:0]                 neg;
    logic                       degen;
  } tfn_side_t;

  function automatic logic [TOP_W-1:0] bitlen(input logic [MAG_W-1:0] v);
    logic [TOP_W-1:0] n;
    n = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (v[i]) n = TOP_W'(i + 1);
    end
    return n;
  endfunction

endpackage

### src/tfn_cross.sv
// Edge vectors, partial products and cross product magnitude and sign.
`timescale 1ns / 1ps
module tfn_cross (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  tfn_pkg::tfn_in_t                    corners,
  output logic                                out_valid,
  output logic [2:0][tfn_pkg::MAG_W-1:0]      mag,
  output logic [2:0]                          neg
);
  localparam int EW = tfn_pkg::EDGE_W;
  localparam int PW = tfn_pkg::PROD_W;
  localparam int CW = tfn_pkg::CROSS_W;

  logic              v1, v2;
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [PW-1:0] p [6];
  logic [CW-1:0]     cr [3];
  logic [2:0][tfn_pkg::MAG_W-1:0] mag_next;
  logic [2:0]        neg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
    e1[0] <= EW'(corners.bx) - EW'(corners.ax);
    e1[1] <= EW'(corners.by) - EW'(corners.ay);
    e1[2] <= EW'(corners.bz) - EW'(corners.az);
    e2[0] <= EW'(corners.cx) - EW'(corners.ax);
    e2[1] <= EW'(corners.cy) - EW'(corners.ay);
    e2[2] <= EW'(corners.cz) - EW'(corners.az);
    p[0] <= e1[1] * e2[2];
    p[1] <= e1[2] * e2[1];
    p[2] <= e1[2] * e2[0];
    p[3] <= e1[0] * e2[2];
    p[4] <= e1[0] * e2[1];
    p[5] <= e1[1] * e2[0];
    mag <= mag_next;
    neg <= neg_next;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr[i] = {p[2*i][PW-1], p[2*i]} - {p[2*i+1][PW-1], p[2*i+1]};
      neg_next[i] = cr[i][CW-1];
      mag_next[i] = neg_next[i] ? tfn_pkg::MAG_W'(-cr[i]) : tfn_pkg::MAG_W'(cr[i]);
    end
  end
endmodule

### src/tfn_scale.sv
// Leading-bit search, common scaling shift, squares and length squared.
`timescale 1ns / 1ps
module tfn_scale (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic [2:0][tfn_pkg::MAG_W-1:0]  mag,
  input  logic [2:0]                      neg,
  output logic                            out_valid,
  output logic [tfn_pkg::LEN_W-1:0]       len,
  output tfn_pkg::tfn_side_t              side
);
  localparam int CB = tfn_pkg::CROSS_BITS;
  localparam int TW = tfn_pkg::TOP_W;

  logic v4, v5, v6;
  logic [TW-1:0] top;
  logic [2:0][tfn_pkg::MAG_W-1:0] mag4;
  logic [2:0] neg4;
  tfn_pkg::tfn_side_t side5, side6, side5_next;
  logic [tfn_pkg::SQ_W-1:0] sq [3];
  logic [tfn_pkg::MAG_W-1:0] shr, shl;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v4 <= in_valid;
      v5 <= v4;
      v6 <= v5;
      out_valid <= v6;
    end
    top   <= tfn_pkg::bitlen(mag[0] | mag[1] | mag[2]);
    mag4  <= mag;
    neg4  <= neg;
    side5 <= side5_next;
    for (int i = 0; i < 3; i++) sq[i] <= side5.sc[i] * side5.sc[i];
    side6 <= side5;
    len   <= tfn_pkg::LEN_W'(sq[0]) + tfn_pkg::LEN_W'(sq[1]) + tfn_pkg::LEN_W'(sq[2]);
    side  <= side6;
  end

  always_comb begin
    side5_next.neg   = neg4;
    side5_next.degen = (top == '0);
    shr = '0;
    shl = '0;
    for (int i = 0; i < 3; i++) begin
      if (top > TW'(CB)) begin
        shr = mag4[i] >> (top - TW'(CB));
        side5_next.sc[i] = shr[CB-1:0];
      end else begin
        shl = mag4[i] << (TW'(CB) - top);
        side5_next.sc[i] = shl[CB-1:0];
      end
    end
  end
endmodule

### src/tfn_rsqrt.sv
// Reciprocal square root, one result bit per pipeline stage.
`timescale 1ns / 1ps
module tfn_rsqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [tfn_pkg::LEN_W-1:0]  len,
  input  tfn_pkg::tfn_side_t         in_side,
  output logic                       out_valid,
  output logic [tfn_pkg::R_W-1:0]    r,
  output tfn_pkg::tfn_side_t         out_side
);
  localparam int RW = tfn_pkg::R_W;
  localparam int QW = tfn_pkg::CAND_W;
  localparam int PW = tfn_pkg::PR_W;
  localparam int LW = tfn_pkg::LEN_W;
  localparam logic [QW-1:0] LIMIT = QW'(1) << (2 * tfn_pkg::RSQ_SHIFT);

  logic               sv [RW+1];
  logic [RW-1:0]      sr [RW+1];
  logic [QW-1:0]      sq [RW+1];
  logic [PW-1:0]      sp [RW+1];
  logic [LW-1:0]      sl [RW+1];
  tfn_pkg::tfn_side_t sd [RW+1];

  assign sv[0] = in_valid;
  assign sr[0] = '0;
  assign sq[0] = '0;
  assign sp[0] = '0;
  assign sl[0] = len;
  assign sd[0] = in_side;

  for (genvar j = 0; j < RW; j++) begin : g_bit
    localparam int B = RW - 1 - j;
    logic [QW-1:0] cand;
    assign cand = sq[j] + (QW'(sp[j]) << (B + 1)) + (QW'(sl[j]) << (2 * B));
    always_ff @(posedge clk) begin
      if (rst) sv[j+1] <= 1'b0;
      else sv[j+1] <= sv[j];
      sl[j+1] <= sl[j];
      sd[j+1] <= sd[j];
      if (cand <= LIMIT) begin
        sr[j+1] <= sr[j] | (RW'(1) << B);
        sq[j+1] <= cand;
        sp[j+1] <= sp[j] + (PW'(sl[j]) << B);
      end else begin
        sr[j+1] <= sr[j];
        sq[j+1] <= sq[j];
        sp[j+1] <= sp[j];
      end
    end
  end

  assign out_valid = sv[RW];
  assign r         = sr[RW];
  assign out_side  = sd[RW];
endmodule

### src/tfn_out.sv
// Component multiply, rounding, saturation, sign and degenerate fallback.
`timescale 1ns / 1ps
module tfn_out (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [tfn_pkg::R_W-1:0]  r,
  input  tfn_pkg::tfn_side_t       side,
  output logic                     done,
  output tfn_pkg::tfn_out_t        normal
);
  localparam int MW = tfn_pkg::MUL_W;
  localparam int NW = tfn_pkg::NORM_W;
  localparam int K  = tfn_pkg::RND_K;

  logic va;
  logic [MW-1:0] prod [3];
  tfn_pkg::tfn_side_t sa;
  logic [MW:0] rnd [3];
  logic [NW-1:0] m [3];
  logic [NW-1:0] comp [3];
  tfn_pkg::tfn_out_t normal_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      done <= 1'b0;
    end else begin
      va <= in_valid;
      done <= va;
    end
    for (int i = 0; i < 3; i++) prod[i] <= MW'(side.sc[i]) * MW'(r);
    sa <= side;
    normal <= normal_next;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = ((MW+1)'(prod[i]) + ((MW+1)'(1) << (K - 1))) >> K;
      m[i] = (rnd[i] > (MW+1)'(tfn_pkg::NORM_MAX)) ? tfn_pkg::NORM_MAX : rnd[i][NW-1:0];
      comp[i] = sa.neg[i] ? -m[i] : m[i];
    end
    if (sa.degen) begin
      normal_next.nx = '0;
      normal_next.ny = tfn_pkg::NORM_MAX;
      normal_next.nz = '0;
      normal_next.degenerate = 1'b1;
    end else begin
      normal_next.nx = comp[0];
      normal_next.ny = comp[1];
      normal_next.nz = comp[2];
      normal_next.degenerate = 1'b0;
    end
  end
endmodule

### src/triangle_flat_normal.sv
// Triangle flat normal: top level tying the pipeline sections together.
`timescale 1ns / 1ps
// One triangle per cycle: busy never rises, and each transfer taken with start
// yields its unit normal on normal, marked by done, after nine arithmetic
// stages plus 32 reciprocal square root stages, one result bit each. The
// receiver cannot stall the pipeline; every result is shown for one cycle
// only and must be taken then.
module triangle_flat_normal (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tfn_pkg::tfn_in_t  corners,
  output logic              done,
  output tfn_pkg::tfn_out_t normal
);
  logic c_valid, s_valid, r_valid;
  logic [2:0][tfn_pkg::MAG_W-1:0] mag;
  logic [2:0] neg;
  logic [tfn_pkg::LEN_W-1:0] len;
  tfn_pkg::tfn_side_t s_side, r_side;
  logic [tfn_pkg::R_W-1:0] r;

  assign busy = 1'b0;

  tfn_cross u_cross (
    .clk, .rst, .in_valid(start && !busy), .corners,
    .out_valid(c_valid), .mag, .neg
  );
  tfn_scale u_scale (
    .clk, .rst, .in_valid(c_valid), .mag, .neg,
    .out_valid(s_valid), .len, .side(s_side)
  );
  tfn_rsqrt u_rsqrt (
    .clk, .rst, .in_valid(s_valid), .len, .in_side(s_side),
    .out_valid(r_valid), .r, .out_side(r_side)
  );
  tfn_out u_out (
    .clk, .rst, .in_valid(r_valid), .r, .side(r_side), .done, .normal
  );
endmodule

### src/tfn_check.sv
// Port-level checks for the triangle flat normal block, bound to the top level.
`timescale 1ns / 1ps
module tfn_check (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input tfn_pkg::tfn_out_t normal
);
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##(tfn_pkg::LATENCY) done)
    else $error("result missing after fixed latency");
  a_fallback: assert property (@(posedge clk) disable iff (rst)
    done && normal.degenerate |->
      normal.nx == '0 && normal.nz == '0 && normal.ny == tfn_pkg::NORM_MAX)
    else $error("bad fallback normal");
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && !normal.degenerate |->
      normal.nx != '0 || normal.ny != '0 || normal.nz != '0)
    else $error("zero normal without degenerate flag");
endmodule

bind triangle_flat_normal tfn_check u_tfn_check (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .done(done), .normal(normal)
);

### tb/sv/tb_triangle_flat_normal.sv
// Testbench for triangle_flat_normal: random and directed triangles checked against a predictor.
`timescale 1ns / 1ps
module tb_triangle_flat_normal;

  class normal_board;
    tfn_pkg::tfn_out_t pending[$];
    int errors = 0;

    function tfn_pkg::tfn_out_t face_normal(tfn_pkg::tfn_in_t t);
      logic signed [tfn_pkg::POS_W:0] e1x, e1y, e1z, e2x, e2y, e2z;
      logic signed [127:0] cr[3];
      logic [127:0] mg[3];
      logic [63:0] sc[3];
      logic [63:0] len2, r, cand, m;
      logic [255:0] prod;
      logic neg[3];
      int topb, b, sh;
      tfn_pkg::tfn_out_t o;
      e1x = t.bx - t.ax; e1y = t.by - t.ay; e1z = t.bz - t.az;
      e2x = t.cx - t.ax; e2y = t.cy - t.ay; e2z = t.cz - t.az;
      cr[0] = 128'(e1y) * 128'(e2z) - 128'(e1z) * 128'(e2y);
      cr[1] = 128'(e1z) * 128'(e2x) - 128'(e1x) * 128'(e2z);
      cr[2] = 128'(e1x) * 128'(e2y) - 128'(e1y) * 128'(e2x);
      topb = 0;
      for (int i = 0; i < 3; i++) begin
        neg[i] = cr[i][127];
        mg[i] = neg[i] ? -cr[i] : cr[i];
        b = 0;
        for (int j = 0; j < 128; j++) if (mg[i][j]) b = j + 1;
        if (b > topb) topb = b;
      end
      if (topb == 0) begin
        o.nx = '0; o.ny = tfn_pkg::NORM_MAX; o.nz = '0; o.degenerate = 1'b1;
        return o;
      end
      for (int i = 0; i < 3; i++) begin
        if (topb > tfn_pkg::CROSS_BITS) begin
          sh = topb - tfn_pkg::CROSS_BITS;
          sc[i] = 64'(mg[i] >> sh);
        end else begin
          sc[i] = 64'(mg[i] << (tfn_pkg::CROSS_BITS - topb));
        end
      end
      len2 = sc[0] * sc[0] + sc[1] * sc[1] + sc[2] * sc[2];
      r = 0;
      for (int bit_i = 31; bit_i >= 0; bit_i--) begin
        cand = r | (64'd1 << bit_i);
        prod = 256'(cand) * 256'(cand) * 256'(len2);
        if (prod <= (256'd1 << (2 * tfn_pkg::RSQ_SHIFT))) r = cand;
      end
      for (int i = 0; i < 3; i++) begin
        m = (sc[i] * r + (64'd1 << (tfn_pkg::RND_K - 1))) >> tfn_pkg::RND_K;
        if (m > 64'(tfn_pkg::NORM_MAX)) m = 64'(tfn_pkg::NORM_MAX);
        if (i == 0) o.nx = neg[i] ? -m[tfn_pkg::NORM_W-1:0] : m[tfn_pkg::NORM_W-1:0];
        if (i == 1) o.ny = neg[i] ? -m[tfn_pkg::NORM_W-1:0] : m[tfn_pkg::NORM_W-1:0];
        if (i == 2) o.nz = neg[i] ? -m[tfn_pkg::NORM_W-1:0] : m[tfn_pkg::NORM_W-1:0];
      end
      o.degenerate = 1'b0;
      return o;
    endfunction

    function void note_triangle(tfn_pkg::tfn_in_t t);
      pending.insert(pending.size(), face_normal(t));
    endfunction

    function void check_normal(tfn_pkg::tfn_out_t got);
      tfn_pkg::tfn_out_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.nx !== exp.nx) begin
        $error("nx expected %0d actual %0d", exp.nx, got.nx); errors++;
      end
      if (got.ny !== exp.ny) begin
        $error("ny expected %0d actual %0d", exp.ny, got.ny); errors++;
      end
      if (got.nz !== exp.nz) begin
        $error("nz expected %0d actual %0d", exp.nz, got.nz); errors++;
      end
      if (got.degenerate !== exp.degenerate) begin
        $error("degenerate expected %0b actual %0b", exp.degenerate, got.degenerate);
        errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG = 2000;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy, done;
  tfn_pkg::tfn_in_t corners = '0;
  tfn_pkg::tfn_out_t normal;
  normal_board board = new();
  int quiet = 0;
  bit calm = 0;

  triangle_flat_normal dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .corners(corners), .done(done), .normal(normal)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) board.note_triangle(corners);
      if (done) board.check_normal(normal);
      if ((start && !busy) || done) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WATCHDOG) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic logic [tfn_pkg::POS_W-1:0] rand_coord();
    unique case ($urandom_range(0, 5))
      0: return {1'b1, {(tfn_pkg::POS_W-1){1'b0}}};
      1: return {1'b0, {(tfn_pkg::POS_W-1){1'b1}}};
      2: return tfn_pkg::POS_W'($urandom_range(0, 15)) - tfn_pkg::POS_W'(8);
      default: return tfn_pkg::POS_W'($urandom);
    endcase
  endfunction

  task automatic send_triangle(tfn_pkg::tfn_in_t t);
    while (!calm && $urandom_range(0, 99) < 27) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    corners <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_random();
    tfn_pkg::tfn_in_t t;
    logic [tfn_pkg::POS_W-1:0] v[9];
    int kind;
    for (int i = 0; i < 9; i++) v[i] = rand_coord();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      // collinear: c = a + 2(b - a)
      for (int i = 0; i < 3; i++) v[6 + i] = (v[3 + i] << 1) - v[i];
    end else if (kind == 1) begin
      for (int i = 0; i < 3; i++) v[3 + i] = v[i];
    end else if (kind == 2) begin
      for (int i = 0; i < 9; i++)
        v[i] = tfn_pkg::POS_W'($urandom_range(0, 7)) - tfn_pkg::POS_W'(4);
    end
    t = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
    send_triangle(t);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  localparam logic [tfn_pkg::POS_W-1:0] PMAX = {1'b0, {(tfn_pkg::POS_W-1){1'b1}}};
  localparam logic [tfn_pkg::POS_W-1:0] PMIN = {1'b1, {(tfn_pkg::POS_W-1){1'b0}}};

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_triangle('0);
    send_triangle({PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX});
    send_triangle({24'd0, 24'd0, 24'd0, 24'd1, 24'd0, 24'd0, 24'd0, 24'd1, 24'd0});
    send_triangle({24'd0, 24'd0, 24'd0, 24'd0, 24'd1, 24'd0, 24'd1, 24'd0, 24'd0});
    send_triangle({24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd1, 24'd1, 24'd0, 24'd0});
    send_triangle({PMIN, PMIN, PMIN, PMAX, PMIN, PMIN, PMIN, PMAX, PMIN});
    send_triangle({PMAX, PMAX, PMAX, PMIN, PMAX, PMAX, PMAX, PMIN, PMAX});
    send_triangle({PMIN, PMIN, PMIN, PMAX, PMAX, PMIN, PMIN, PMAX, PMAX});
    send_triangle({PMIN, 24'd0, PMAX, PMAX, PMIN, 24'd0, 24'd0, PMAX, PMIN});
    send_triangle({24'd0, 24'd0, 24'd0, 24'd1, 24'd1, 24'd1, 24'd2, 24'd2, 24'd2});
    send_triangle({24'd3, 24'd0, 24'd0, 24'd0, 24'd4, 24'd0, 24'd0, 24'd0, 24'd5});
    send_triangle({24'd0, 24'd0, 24'd0, 24'd1, 24'd2, 24'd0, 24'd3, 24'd5, 24'd0});
    drain();
    for (int n = 0; n < 500; n++) begin
      calm = (n >= 200 && n < 280);
      send_random();
      if (n == 350) drain();
    end
    drain();
    repeat (tfn_pkg::LATENCY + 5) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

### triangle_flat_normal.f
src/tfn_pkg.sv
src/tfn_cross.sv
src/tfn_scale.sv
src/tfn_rsqrt.sv
src/tfn_out.sv
src/triangle_flat_normal.sv
src/tfn_check.sv
tb/sv/tb_triangle_flat_normal.sv
